@@ hw/rtl/vau_pkg.sv @@
// Shared constants, command/status types and helper functions for the vector angle unit.
// Used by vau_ctrl, vau_dp and vector_angle_unit.
`default_nettype none
package vau_pkg;

	localparam int MAX_DIM     = 256;
	localparam int ELEM_WIDTH  = 16;
	localparam int ACOS_ITERS  = 16;
	localparam int ATAN_ROUNDS = 24;
	localparam int CORDIC_ROUNDS = (ACOS_ITERS < ATAN_ROUNDS) ? ACOS_ITERS : ATAN_ROUNDS;

	localparam int SUM_W   = 40;
	localparam int PROD_W  = 2 * ELEM_WIDTH;
	localparam int EXT_W   = SUM_W + 2;
	localparam int CNT_W   = $clog2(MAX_DIM + 1);
	localparam int RAD_W   = 56;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = 16;
	localparam int STEP_W  = 5;
	localparam int COS_W   = 17;
	localparam int CSQ_W   = 33;
	localparam int CRD_W   = 20;
	localparam int ANGLE_W = 15;

	localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
	localparam logic [17:0] PI_Q16      = 18'd205887;
	localparam logic [ANGLE_W-1:0] PI_Q13 = 15'd25736;
	localparam logic [COS_W-1:0]   ONE_Q16 = 17'd65536;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ROOT_LOAD_A,
		OP_ROOT_LOAD_B,
		OP_ROOT_LOAD_S,
		OP_ROOT_STEP,
		OP_MUL,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_CSQ,
		OP_CORDIC_LOAD,
		OP_CORDIC_STEP,
		OP_RESULT
	} op_t;

	typedef struct packed {
		logic              acc;
		logic              last;
		op_t               op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic out_free;
	} sts_t;

	function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [15:0] r;
		unique case (i)
			5'd0:    r = 16'd51472;
			5'd1:    r = 16'd30386;
			5'd2:    r = 16'd16055;
			5'd3:    r = 16'd8150;
			5'd4:    r = 16'd4091;
			5'd5:    r = 16'd2047;
			5'd6:    r = 16'd1024;
			5'd7:    r = 16'd512;
			5'd8:    r = 16'd256;
			5'd9:    r = 16'd128;
			5'd10:   r = 16'd64;
			5'd11:   r = 16'd32;
			5'd12:   r = 16'd16;
			5'd13:   r = 16'd8;
			5'd14:   r = 16'd4;
			5'd15:   r = 16'd2;
			5'd16:   r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// {saturated, sum}
	function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] acc,
			input logic signed [PROD_W-1:0] p);
		logic signed [EXT_W-1:0] s;
		s = EXT_W'(acc) + EXT_W'(p);
		if (s > EXT_W'(SUM_MAX))
			return {1'b1, SUM_MAX};
		else if (s < EXT_W'(SUM_MIN))
			return {1'b1, SUM_MIN};
		else
			return {1'b0, s[SUM_W-1:0]};
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/vau_ctrl.sv @@
// Sequencer for the vector angle unit: accepts pairs and steps the finishing datapath.
// Depends on vau_pkg.
`default_nettype none
module vau_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          last_pair,
	output logic               in_stall,
	input  vau_pkg::sts_t      sts,
	output vau_pkg::cmd_t      cmd
);
	import vau_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD_A,
		S_ROOT_A,
		S_LOAD_B,
		S_ROOT_B,
		S_MUL,
		S_CHECK,
		S_DIV,
		S_CSQ,
		S_LOAD_S,
		S_ROOT_S,
		S_CORD_LOAD,
		S_CORDIC,
		S_DONE
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] cnt_q;

	always_comb begin
		in_stall = (state_q != S_IDLE);
		cmd.acc  = in_valid && (state_q == S_IDLE);
		cmd.last = last_pair;
		cmd.step = cnt_q;
		unique case (state_q)
			S_LOAD_A:    cmd.op = OP_ROOT_LOAD_A;
			S_LOAD_B:    cmd.op = OP_ROOT_LOAD_B;
			S_LOAD_S:    cmd.op = OP_ROOT_LOAD_S;
			S_ROOT_A,
			S_ROOT_B,
			S_ROOT_S:    cmd.op = OP_ROOT_STEP;
			S_MUL:       cmd.op = OP_MUL;
			S_CHECK:     cmd.op = OP_DIV_LOAD;
			S_DIV:       cmd.op = OP_DIV_STEP;
			S_CSQ:       cmd.op = OP_CSQ;
			S_CORD_LOAD: cmd.op = OP_CORDIC_LOAD;
			S_CORDIC:    cmd.op = OP_CORDIC_STEP;
			S_DONE:      cmd.op = sts.out_free ? OP_RESULT : OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.acc && last_pair)
						state_q <= S_LOAD_A;
				end
				S_LOAD_A: begin
					cnt_q   <= '0;
					state_q <= S_ROOT_A;
				end
				S_ROOT_A: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(ROOT_STEPS - 1))
						state_q <= S_LOAD_B;
				end
				S_LOAD_B: begin
					cnt_q   <= '0;
					state_q <= S_ROOT_B;
				end
				S_ROOT_B: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(ROOT_STEPS - 1))
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_CHECK;
				S_CHECK: begin
					cnt_q   <= '0;
					state_q <= sts.zero ? S_DONE : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(DIV_STEPS - 1))
						state_q <= S_CSQ;
				end
				S_CSQ: state_q <= S_LOAD_S;
				S_LOAD_S: begin
					cnt_q   <= '0;
					state_q <= S_ROOT_S;
				end
				S_ROOT_S: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(ROOT_STEPS - 1))
						state_q <= S_CORD_LOAD;
				end
				S_CORD_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(CORDIC_ROUNDS - 1))
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc && last_pair |=> state_q == S_LOAD_A)
		else $error("finish did not start after last pair");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= STEP_W'(ROOT_STEPS))
		else $error("step counter out of range");

endmodule
`default_nettype wire

@@ hw/rtl/vau_dp.sv @@
// Datapath: saturating accumulators, shared square root, divider, CORDIC and result register.
// Depends on vau_pkg; driven by vau_ctrl commands.
`default_nettype none
module vau_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  vau_pkg::cmd_t                   cmd,
	output vau_pkg::sts_t                   sts,
	input  wire logic [15:0]                a_elem,
	input  wire logic [15:0]                b_elem,
	input  wire logic                       cfg_we,
	input  wire logic [15:0]                cfg_wdata,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [vau_pkg::ANGLE_W-1:0]     angle,
	output logic signed [vau_pkg::SUM_W-1:0] dot_value,
	output logic                            zero_vector,
	output logic                            overflowed
);
	import vau_pkg::*;

	logic [15:0] thr_q;
	logic signed [SUM_W-1:0] dot_q, sqa_q, sqb_q;
	logic [CNT_W-1:0] count_q;
	logic ovf_q;
	logic signed [SUM_W-1:0] fdot_q, fsqa_q, fsqb_q;
	logic fovf_q;

	logic [RAD_W-1:0]  v_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q, na_q;
	logic [RAD_W-1:0]  prod_q;
	logic [RAD_W:0]    r_q;
	logic [DIV_STEPS-1:0] q_q;
	logic clamp_q, zero_q;
	logic [COS_W-1:0] c_q;
	logic [CSQ_W-1:0] csq_q;
	logic signed [CRD_W-1:0] x_q, y_q, z_q;

	logic signed [ELEM_WIDTH-1:0] a_s, b_s;
	logic signed [PROD_W-1:0] ab, aa, bb;
	logic [SUM_W:0] sd, sa, sb;
	logic full;
	logic signed [SUM_W-1:0] dot_n, sqa_n, sqb_n;
	logic ovf_n;

	logic [SUM_W-1:0] mag;
	logic [REM_W-1:0] rem_sh, trial;
	logic [RAD_W:0] r_sh;
	logic [COS_W-1:0] c_n;
	logic [2*COS_W-1:0] csq_full;
	logic signed [CRD_W-1:0] dx, dy, at;
	logic [16:0] zc;
	logic [17:0] zt;
	logic [ANGLE_W:0] zr;
	logic [ANGLE_W-1:0] ang;

	always_comb begin
		a_s = a_elem[ELEM_WIDTH-1:0];
		b_s = b_elem[ELEM_WIDTH-1:0];
		ab = a_s * b_s;
		aa = a_s * a_s;
		bb = b_s * b_s;
		sd = sat_add(dot_q, ab);
		sa = sat_add(sqa_q, aa);
		sb = sat_add(sqb_q, bb);
		full = (count_q >= CNT_W'(MAX_DIM));
		if (full) begin
			dot_n = dot_q;
			sqa_n = sqa_q;
			sqb_n = sqb_q;
			ovf_n = 1'b1;
		end else begin
			dot_n = sd[SUM_W-1:0];
			sqa_n = sa[SUM_W-1:0];
			sqb_n = sb[SUM_W-1:0];
			ovf_n = ovf_q | sd[SUM_W] | sa[SUM_W] | sb[SUM_W];
		end

		mag    = fdot_q[SUM_W-1] ? SUM_W'(-fdot_q) : SUM_W'(fdot_q);
		rem_sh = {rem_q[REM_W-3:0], v_q[RAD_W-1:RAD_W-2]};
		trial  = {1'b0, root_q, 2'b01};
		r_sh   = {r_q[RAD_W-1:0], 1'b0};
		c_n    = clamp_q ? ONE_Q16 : {1'b0, q_q};
		csq_full = 34'h1_0000_0000 - c_n * c_n;

		dx = y_q >>> cmd.step;
		dy = x_q >>> cmd.step;
		at = CRD_W'(atan_q16(cmd.step));

		if (z_q < 0)
			zc = '0;
		else if (z_q > CRD_W'(HALF_PI_Q16))
			zc = HALF_PI_Q16;
		else
			zc = z_q[16:0];
		zt = fdot_q[SUM_W-1] ? PI_Q16 - {1'b0, zc} : {1'b0, zc};
		zr = (ANGLE_W+1)'((zt + 18'd4) >> 3);
		ang = (zr > {1'b0, PI_Q13}) ? PI_Q13 : zr[ANGLE_W-1:0];

		sts.zero     = prod_q[RAD_W-1:16] <= (RAD_W-16)'(thr_q);
		sts.out_free = !out_valid || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= 16'd1;
			dot_q     <= '0;
			sqa_q     <= '0;
			sqb_q     <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we)
				thr_q <= cfg_wdata;
			if (cmd.acc) begin
				if (cmd.last) begin
					dot_q   <= '0;
					sqa_q   <= '0;
					sqb_q   <= '0;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					dot_q <= dot_n;
					sqa_q <= sqa_n;
					sqb_q <= sqb_n;
					ovf_q <= ovf_n;
					if (!full)
						count_q <= count_q + 1'b1;
				end
			end
			if (cmd.op == OP_RESULT)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc && cmd.last) begin
			fdot_q <= dot_n;
			fsqa_q <= sqa_n;
			fsqb_q <= sqb_n;
			fovf_q <= ovf_n;
		end
		unique case (cmd.op)
			OP_ROOT_LOAD_A: begin
				v_q    <= RAD_W'(fsqa_q[SUM_W-2:0]) << 16;
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_ROOT_LOAD_B: begin
				na_q   <= root_q;
				v_q    <= RAD_W'(fsqb_q[SUM_W-2:0]) << 16;
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_ROOT_LOAD_S: begin
				v_q    <= RAD_W'(csq_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_ROOT_STEP: begin
				v_q <= v_q << 2;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			OP_MUL: prod_q <= na_q * root_q;
			OP_DIV_LOAD: begin
				r_q     <= {1'b0, mag[RAD_W-17:0], 16'b0};
				clamp_q <= {mag[RAD_W-17:0], 16'b0} >= prod_q;
				q_q     <= '0;
				zero_q  <= sts.zero;
			end
			OP_DIV_STEP: begin
				if (r_sh >= {1'b0, prod_q}) begin
					r_q <= r_sh - {1'b0, prod_q};
					q_q <= {q_q[DIV_STEPS-2:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[DIV_STEPS-2:0], 1'b0};
				end
			end
			OP_CSQ: begin
				c_q   <= c_n;
				csq_q <= csq_full[CSQ_W-1:0];
			end
			OP_CORDIC_LOAD: begin
				x_q <= CRD_W'(c_q);
				y_q <= CRD_W'(root_q);
				z_q <= '0;
			end
			OP_CORDIC_STEP: begin
				if (y_q > 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end
			end
			OP_RESULT: begin
				angle       <= zero_q ? '0 : ang;
				dot_value   <= fdot_q;
				zero_vector <= zero_q;
				overflowed  <= fovf_q;
			end
			default: begin
			end
		endcase
	end

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> angle == '0)
		else $error("zero vector result with nonzero angle");
	a_angle_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle <= PI_Q13)
		else $error("angle above pi");

endmodule
`default_nettype wire

@@ hw/rtl/vector_angle_unit.sv @@
// Angle between two vectors: pair accumulator and multicycle finishing unit.
// Depends on vau_pkg, vau_ctrl and vau_dp.
//
// Element pairs are taken one per clock while the block is accumulating. The pair
// that carries last_pair starts the finishing sequence, during which input is
// stalled: two passes of the one-bit-per-cycle square root unit (28-bit roots),
// a norm product, a restoring divide to 16 quotient bits, a third root pass and a
// 16-round CORDIC. The divide, the third root pass and the CORDIC are skipped when
// the norm product falls at or below the threshold set through cfg_wdata. The
// result sits in an output register, so accumulation of the next vectors
// continues while a finished result waits to be taken.
`default_nettype none
module vector_angle_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [15:0]          a_elem,
	input  wire logic signed [15:0]          b_elem,
	input  wire logic                        last_pair,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [vau_pkg::ANGLE_W-1:0]      angle,
	output logic signed [vau_pkg::SUM_W-1:0] dot_value,
	output logic                             zero_vector,
	output logic                             overflowed,
	input  wire logic                        cfg_we,
	input  wire logic [15:0]                 cfg_wdata
);
	import vau_pkg::*;

	cmd_t cmd;
	sts_t sts;

	vau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_pair (last_pair),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vau_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.a_elem      (a_elem),
		.b_elem      (b_elem),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.angle       (angle),
		.dot_value   (dot_value),
		.zero_vector (zero_vector),
		.overflowed  (overflowed)
	);

endmodule
`default_nettype wire

@@ verif/vector_angle_unit_test.sv @@
// Self-checking bench for vector_angle_unit: streams element pairs, predicts each angle result.
// Depends on vau_pkg and the vector_angle_unit RTL; needs no files or arguments.
`default_nettype none
module vector_angle_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vau_pkg::*;

	typedef struct {
		logic [ANGLE_W-1:0]      angle;
		logic signed [SUM_W-1:0] dot;
		logic                    zero;
		logic                    ovf;
	} angle_res_t;

	typedef struct {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               last;
		bit                 typed;
		angle_res_t         res;
	} pair_row_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	logic signed [15:0] a_elem = 0, b_elem = 0;
	logic last_pair = 0;
	logic out_valid, out_stall = 0;
	logic [ANGLE_W-1:0] angle;
	logic signed [SUM_W-1:0] dot_value;
	logic zero_vector, overflowed;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = 0;

	vector_angle_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_elem(a_elem), .b_elem(b_elem), .last_pair(last_pair),
		.out_valid(out_valid), .out_stall(out_stall),
		.angle(angle), .dot_value(dot_value), .zero_vector(zero_vector),
		.overflowed(overflowed),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	longint dot_acc, sqa_acc, sqb_acc;
	int pairs_in_vec;
	bit sticky_ovf;
	logic [15:0] threshold;

	angle_res_t pending_angles[$];
	bit gaps_on = 1;
	bit failed = 0;
	int items_sent = 0, results_checked = 0, zero_results = 0, ovf_results = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("vector_angle_unit_test: FAIL");
		$finish;
	end

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else
				r >>= 1;
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic logic [ANGLE_W-1:0] angle_of(longint unsigned mag,
			longint unsigned prod, bit neg);
		longint unsigned num, rem, q;
		longint c, s, x, y, z, dx, dy;
		longint atans[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
		num = mag << 16;
		if (num >= prod)
			c = 65536;
		else begin
			rem = num;
			q = 0;
			for (int i = 0; i < 16; i++) begin
				rem <<= 1;
				q <<= 1;
				if (rem >= prod) begin
					rem -= prod;
					q |= 1;
				end
			end
			c = q;
		end
		s = root_floor((64'd1 << 32) - c * c);
		x = c;
		y = s;
		z = 0;
		for (int i = 0; i < ACOS_ITERS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atans[i];
			end else begin
				x -= dx; y += dy; z -= atans[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 102944) z = 102944;
		if (neg) z = 205887 - z;
		z = (z + 4) >>> 3;
		if (z > 25736) z = 25736;
		return z[ANGLE_W-1:0];
	endfunction

	function automatic longint sat40(longint v);
		if (v > 64'sd549755813887) begin
			sticky_ovf = 1;
			return 64'sd549755813887;
		end
		if (v < -64'sd549755813888) begin
			sticky_ovf = 1;
			return -64'sd549755813888;
		end
		return v;
	endfunction

	function automatic angle_res_t accumulate_pair(logic signed [15:0] a,
			logic signed [15:0] b, logic l, output bit done);
		angle_res_t r;
		longint av, bv;
		longint unsigned na, nb, prod, mag;
		av = a;
		bv = b;
		done = 0;
		r = '{0, 0, 0, 0};
		if (pairs_in_vec >= MAX_DIM)
			sticky_ovf = 1;
		else begin
			dot_acc = sat40(dot_acc + av * bv);
			sqa_acc = sat40(sqa_acc + av * av);
			sqb_acc = sat40(sqb_acc + bv * bv);
			pairs_in_vec++;
		end
		if (!l) return r;
		done = 1;
		na = root_floor(longint'(sqa_acc) << 16);
		nb = root_floor(longint'(sqb_acc) << 16);
		prod = na * nb;
		r.zero = (prod >> 16) <= threshold;
		if (!r.zero) begin
			mag = dot_acc < 0 ? -dot_acc : dot_acc;
			r.angle = angle_of(mag, prod, dot_acc < 0);
		end
		r.dot = dot_acc[SUM_W-1:0];
		r.ovf = sticky_ovf;
		dot_acc = 0; sqa_acc = 0; sqb_acc = 0; pairs_in_vec = 0; sticky_ovf = 0;
		return r;
	endfunction

	task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic l,
			bit typed, angle_res_t typed_res);
		angle_res_t r;
		bit done;
		while (gaps_on && $urandom_range(99) < 34) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		a_elem <= a;
		b_elem <= b;
		last_pair <= l;
		do @(posedge clk); while (in_stall);
		items_sent++;
		r = accumulate_pair(a, b, l, done);
		if (done) pending_angles.push_back(typed ? typed_res : r);
	endtask

	task automatic write_threshold(logic [15:0] v);
		in_valid <= 0;
		@(posedge clk);
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		threshold = v;
	endtask

	function automatic logic signed [15:0] pick_elem(int mode);
		case (mode)
			0: return 16'($urandom_range(6) - 3);
			1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_vectors(int n_items);
		int goal, len, mode;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			len = ($urandom_range(99) < 3) ? $urandom_range(300, 240) : $urandom_range(8, 1);
			mode = $urandom_range(5) < 1 ? 0 : ($urandom_range(9) < 1 ? 1 : 2);
			for (int k = 0; k < len; k++)
				send_pair(pick_elem(mode), pick_elem(mode), k == len - 1, 0, '{0, 0, 0, 0});
		end
	endtask

	always @(posedge clk) begin
		angle_res_t e;
		if (out_valid && !out_stall) begin
			if (pending_angles.size() == 0) begin
				$error("result with no expectation pending");
				failed = 1;
			end else begin
				e = pending_angles.pop_front();
				results_checked++;
				if (e.zero) zero_results++;
				if (e.ovf) ovf_results++;
				if (angle !== e.angle) begin
					$error("angle: expected %0d, got %0d", e.angle, angle);
					failed = 1;
				end
				if (dot_value !== e.dot) begin
					$error("dot_value: expected %0d, got %0d", e.dot, dot_value);
					failed = 1;
				end
				if (zero_vector !== e.zero) begin
					$error("zero_vector: expected %0d, got %0d", e.zero, zero_vector);
					failed = 1;
				end
				if (overflowed !== e.ovf) begin
					$error("overflowed: expected %0d, got %0d", e.ovf, overflowed);
					failed = 1;
				end
			end
		end
		out_stall <= gaps_on ? ($urandom_range(99) < 34) : 1'b0;
	end

	pair_row_t directed[] = '{
		'{16'sd0, 16'sd0, 1, 1, '{0, 0, 1, 0}},
		'{16'sd1, 16'sd1, 1, 1, '{0, 1, 1, 0}},
		'{16'sd0, -16'sd1, 1, 1, '{0, 0, 1, 0}},
		'{16'sd0, 16'sd32767, 1, 1, '{0, 0, 1, 0}},
		'{16'sd4096, 16'sd4096, 1, 0, '{0, 0, 0, 0}},
		'{16'sd4096, -16'sd4096, 1, 0, '{0, 0, 0, 0}},
		'{16'sd32767, 16'sd32767, 1, 0, '{0, 0, 0, 0}},
		'{-16'sd32768, -16'sd32768, 1, 0, '{0, 0, 0, 0}},
		'{-16'sd32768, 16'sd32767, 1, 0, '{0, 0, 0, 0}},
		'{16'sd4096, 16'sd0, 0, 0, '{0, 0, 0, 0}},
		'{16'sd0, 16'sd4096, 0, 0, '{0, 0, 0, 0}},
		'{16'sd0, 16'sd0, 1, 0, '{0, 0, 0, 0}},
		'{16'sh5555, -16'sh2aab, 0, 0, '{0, 0, 0, 0}},
		'{-16'sh5556, 16'sh2aaa, 1, 0, '{0, 0, 0, 0}},
		'{16'sd3000, 16'sd2000, 0, 0, '{0, 0, 0, 0}},
		'{-16'sd1000, 16'sd2500, 0, 0, '{0, 0, 0, 0}},
		'{16'sd700, 16'sd700, 1, 0, '{0, 0, 0, 0}}
	};

	initial begin
		dot_acc = 0; sqa_acc = 0; sqb_acc = 0; pairs_in_vec = 0; sticky_ovf = 0;
		threshold = 16'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i])
			send_pair(directed[i].a, directed[i].b, directed[i].last,
				directed[i].typed, directed[i].res);
		write_threshold(16'd0);
		random_vectors(220);
		gaps_on = 0;
		write_threshold(16'hffff);
		random_vectors(220);
		gaps_on = 1;
		write_threshold(16'($urandom_range(65535)));
		random_vectors(220);
		write_threshold(16'd1);
		random_vectors(220);
		in_valid <= 0;
		@(posedge clk);
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		$display("Sent %0d element pairs, checked %0d angle results (%0d zero-vector, %0d overflow).",
			items_sent, results_checked, zero_results, ovf_results);
		$display("Thresholds covered: reset value, 0, 65535 and one random value.");
		if (!failed)
			$display("vector_angle_unit_test: PASS");
		else
			$display("vector_angle_unit_test: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/vau_pkg.sv
hw/rtl/vau_ctrl.sv
hw/rtl/vau_dp.sv
hw/rtl/vector_angle_unit.sv
verif/vector_angle_unit_test.sv
